// ===== rtl/rlrp_pkg.sv =====
package rlrp_pkg;

   // screen geometry
   localparam int SCREEN_WIDTH  = 160;
   localparam int SCREEN_HEIGHT = 100;
   localparam int MEM_DEPTH     = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W        = $clog2(MEM_DEPTH);
   localparam int XW            = $clog2(SCREEN_WIDTH);
   localparam int YW            = $clog2(SCREEN_HEIGHT);

   // field widths
   localparam int COORD_W = 12;
   localparam int COLOR_W = 4;
   localparam int ERR_W   = COORD_W + 3;

   // register byte addresses
   localparam logic [2:0] REG_DRAW_ENABLE = 3'h0;
   localparam logic [2:0] REG_DRAW_COLOR  = 3'h4;

   typedef enum logic [1:0] {
      KIND_PLOT = 2'd0,
      KIND_LINE = 2'd1,
      KIND_RECT = 2'd2,
      KIND_READ = 2'd3
   } rlrp_kind_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic load;
      logic line_step;
      logic rect_step;
      logic read_capture;
      logic rsp_load;
   } rlrp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_last;
      logic line_last;
      logic rect_last;
      logic rect_empty;
      logic rsp_busy;
   } rlrp_sts_type;

endpackage

// ===== rtl/raster_line_rect_plotter.sv =====
// Sequence: a plot or a line walks its path and writes the on-screen pixels, a
// rectangle its on-screen pixels (none when it is empty), a read captures the
// stored pixel, and a draw command taken while drawing is disabled goes straight to the result.
// Throughput: one command at a time, one pixel per cycle into the single-port store.
// Reset enables drawing, zeroes the color and then sweeps the frame store to zero,
// one pixel per cycle, with req_tready low; register writes are taken.
module raster_line_rect_plotter (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: x_start[11:0], y_start[23:12], x_end[35:24], y_end[47:36],
   //            rect_width[59:48], rect_height[71:60]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,
   // req_tuser: req_type[1:0]
   input  logic [1:0]  req_tuser,
   // rsp_tdata: read_color[3:0], zero fill [7:4]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW = rlrp_pkg::COORD_W;

   rlrp_pkg::rlrp_cmd_type  cmd;
   rlrp_pkg::rlrp_sts_type  sts;
   rlrp_pkg::rlrp_kind_type req_kind;
   logic                    draw_enable_ff;
   logic [rlrp_pkg::COLOR_W-1:0] draw_color_ff, rsp_color;
   logic                    csr_wr;

   assign req_kind = rlrp_pkg::rlrp_kind_type'(req_tuser);

   // register file: word select on address bit 2
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_enable_ff <= 1'b1;
         draw_color_ff  <= '0;
      end else if (csr_wr) begin
         if (csr_paddr[2] == rlrp_pkg::REG_DRAW_COLOR[2]) begin
            draw_color_ff <= csr_pwdata[rlrp_pkg::COLOR_W-1:0];
         end else begin
            draw_enable_ff <= csr_pwdata[0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == rlrp_pkg::REG_DRAW_COLOR[2]) begin
         csr_prdata = 32'(draw_color_ff);
      end else begin
         csr_prdata = 32'(draw_enable_ff);
      end
   end

   rlrp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_kind    (req_kind),
      .draw_enable (draw_enable_ff),
      .sts         (sts),
      .cmd         (cmd)
   );

   rlrp_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_kind    (req_kind),
      .x_start     ($signed(req_tdata[CW-1:0])),
      .y_start     ($signed(req_tdata[2*CW-1:CW])),
      .x_end       ($signed(req_tdata[3*CW-1:2*CW])),
      .y_end       ($signed(req_tdata[4*CW-1:3*CW])),
      .rect_width  ($signed(req_tdata[5*CW-1:4*CW])),
      .rect_height ($signed(req_tdata[6*CW-1:5*CW])),
      .draw_color  (draw_color_ff),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_color   (rsp_color)
   );

   assign rsp_tdata = 8'(rsp_color);

endmodule

// ===== rtl/rlrp_ctrl.sv =====
module rlrp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  rlrp_pkg::rlrp_kind_type req_kind,
   input  logic                   draw_enable,
   input  rlrp_pkg::rlrp_sts_type  sts,
   output rlrp_pkg::rlrp_cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_LINE  = 6'b000100,
      ST_RECT  = 6'b001000,
      ST_READ  = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_kind == rlrp_pkg::KIND_READ) state_in = ST_READ;
               else if (!draw_enable) state_in = ST_RESP;
               else if (req_kind == rlrp_pkg::KIND_RECT) state_in = ST_RECT;
               else state_in = ST_LINE;
            end
         end
         ST_LINE: begin
            cmd.line_step = 1'b1;
            if (sts.line_last) state_in = ST_RESP;
         end
         ST_RECT: begin
            if (sts.rect_empty) begin
               state_in = ST_RESP;
            end else begin
               cmd.rect_step = 1'b1;
               if (sts.rect_last) state_in = ST_RESP;
            end
         end
         ST_READ: begin
            cmd.read_capture = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else state_ff <= state_in;
   end

   a_clear_to_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && sts.clear_last) |=> state_ff == ST_IDLE)
      else $error("clearing pass did not end in idle");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff != ST_IDLE)
      else $error("accepted beat did not start work");

endmodule

// ===== rtl/rlrp_datapath.sv =====
module rlrp_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rlrp_pkg::rlrp_cmd_type               cmd,
   output rlrp_pkg::rlrp_sts_type               sts,
   input  rlrp_pkg::rlrp_kind_type              req_kind,
   input  logic signed [rlrp_pkg::COORD_W-1:0] x_start,
   input  logic signed [rlrp_pkg::COORD_W-1:0] y_start,
   input  logic signed [rlrp_pkg::COORD_W-1:0] x_end,
   input  logic signed [rlrp_pkg::COORD_W-1:0] y_end,
   input  logic signed [rlrp_pkg::COORD_W-1:0] rect_width,
   input  logic signed [rlrp_pkg::COORD_W-1:0] rect_height,
   input  logic [rlrp_pkg::COLOR_W-1:0]        draw_color,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [rlrp_pkg::COLOR_W-1:0]        rsp_color
);

   localparam int CW = rlrp_pkg::COORD_W;
   localparam int EW = rlrp_pkg::ERR_W;
   localparam int AW = rlrp_pkg::ADDR_W;
   localparam logic signed [CW:0] SCR_W = (CW+1)'(rlrp_pkg::SCREEN_WIDTH);
   localparam logic signed [CW:0] SCR_H = (CW+1)'(rlrp_pkg::SCREEN_HEIGHT);

   // cursor and line walker state
   logic signed [CW-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [CW-1:0] end_x_ff, end_y_ff;
   logic signed [EW-1:0] dx_ff, dy_ff, err_ff, err_in;
   logic                 sx_neg_ff, sy_neg_ff;
   // rectangle limits
   logic signed [CW-1:0] rx_first_ff, rx_last_ff, ry_last_ff;
   logic                 rect_empty_ff;
   // clearing sweep, read back and response
   logic [AW-1:0]        clr_cnt_ff;
   logic                 rd_on_ff;
   logic [rlrp_pkg::COLOR_W-1:0] rd_data_ff;
   logic                 rsp_valid_ff;
   logic [rlrp_pkg::COLOR_W-1:0] rsp_color_ff;
   logic [rlrp_pkg::COLOR_W-1:0] mem [rlrp_pkg::MEM_DEPTH];

   // load-time line setup
   logic signed [CW:0]   ld_end_x, ld_end_y, ddx, ddy;
   logic signed [EW-1:0] ld_dx, ld_dy;
   always_comb begin
      ld_end_x = (req_kind == rlrp_pkg::KIND_PLOT) ? (CW+1)'(x_start) : (CW+1)'(x_end);
      ld_end_y = (req_kind == rlrp_pkg::KIND_PLOT) ? (CW+1)'(y_start) : (CW+1)'(y_end);
      ddx = ld_end_x - (CW+1)'(x_start);
      ddy = ld_end_y - (CW+1)'(y_start);
      ld_dx = (ddx < 0) ? EW'(-ddx) : EW'(ddx);
      ld_dy = (ddy < 0) ? EW'(-ddy) : EW'(ddy);
   end

   // load-time rectangle clamp to the screen
   logic signed [CW:0] xs1, ys1, w1, h1, xsum, ysum, xa, ya, xb, yb, xl, yl;
   logic               ld_rect_empty;
   always_comb begin
      xs1 = (CW+1)'(x_start);
      ys1 = (CW+1)'(y_start);
      w1  = (CW+1)'(rect_width);
      h1  = (CW+1)'(rect_height);
      xsum = xs1 + w1;
      ysum = ys1 + h1;
      xa = (xs1 < 0) ? '0 : xs1;
      ya = (ys1 < 0) ? '0 : ys1;
      xb = (xsum > SCR_W) ? SCR_W : xsum;
      yb = (ysum > SCR_H) ? SCR_H : ysum;
      xl = xb - (CW+1)'(1);
      yl = yb - (CW+1)'(1);
      ld_rect_empty = (w1 <= 0) || (h1 <= 0) || (xa >= xb) || (ya >= yb);
   end

   // pixel address and clipping
   logic          on_screen, line_last, rect_x_last, mem_we;
   logic [AW-1:0] pix_addr, mem_addr;
   always_comb begin
      on_screen = (cur_x_ff >= 0) && ((CW+1)'(cur_x_ff) < SCR_W) &&
                  (cur_y_ff >= 0) && ((CW+1)'(cur_y_ff) < SCR_H);
      pix_addr = AW'(AW'(cur_y_ff[rlrp_pkg::YW-1:0]) * AW'(rlrp_pkg::SCREEN_WIDTH))
               + AW'(cur_x_ff[rlrp_pkg::XW-1:0]);
      mem_addr = cmd.clear ? clr_cnt_ff : pix_addr;
      mem_we   = cmd.clear || ((cmd.line_step || cmd.rect_step) && on_screen);
      line_last   = (cur_x_ff == end_x_ff) && (cur_y_ff == end_y_ff);
      rect_x_last = (cur_x_ff == rx_last_ff);
   end

   // Bresenham error step
   logic signed [EW:0] e2;
   logic               mv_x, mv_y;
   always_comb begin
      e2   = {err_ff, 1'b0};
      mv_x = e2 >= -(EW+1)'(dy_ff);
      mv_y = e2 <= (EW+1)'(dx_ff);
      err_in = err_ff - (mv_x ? dy_ff : '0) + (mv_y ? dx_ff : '0);
   end

   // advance the cursor
   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      if (cmd.load) begin
         if (req_kind == rlrp_pkg::KIND_RECT) begin
            cur_x_in = CW'(xa);
            cur_y_in = CW'(ya);
         end else begin
            cur_x_in = x_start;
            cur_y_in = y_start;
         end
      end else if (cmd.line_step && !line_last) begin
         if (mv_x) cur_x_in = sx_neg_ff ? cur_x_ff - CW'(1) : cur_x_ff + CW'(1);
         if (mv_y) cur_y_in = sy_neg_ff ? cur_y_ff - CW'(1) : cur_y_ff + CW'(1);
      end else if (cmd.rect_step) begin
         if (rect_x_last) begin
            cur_x_in = rx_first_ff;
            cur_y_in = cur_y_ff + CW'(1);
         end else begin
            cur_x_in = cur_x_ff + CW'(1);
         end
      end
   end

   // walker payload registers
   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      if (cmd.load) begin
         end_x_ff      <= CW'(ld_end_x);
         end_y_ff      <= CW'(ld_end_y);
         dx_ff         <= ld_dx;
         dy_ff         <= ld_dy;
         err_ff        <= ld_dx - ld_dy;
         sx_neg_ff     <= ddx < 0;
         sy_neg_ff     <= ddy < 0;
         rx_first_ff   <= CW'(xa);
         rx_last_ff    <= CW'(xl);
         ry_last_ff    <= CW'(yl);
         rect_empty_ff <= ld_rect_empty;
      end else if (cmd.line_step) begin
         err_ff <= err_in;
      end
   end

   // frame store: one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= cmd.clear ? '0 : draw_color;
      rd_data_ff <= mem[mem_addr];
   end

   // clearing sweep counter and read flag
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         rd_on_ff   <= 1'b0;
      end else begin
         if (cmd.clear) clr_cnt_ff <= clr_cnt_ff + AW'(1);
         if (cmd.load) rd_on_ff <= 1'b0;
         else if (cmd.read_capture) rd_on_ff <= on_screen;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) rsp_color_ff <= rd_on_ff ? rd_data_ff : '0;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_color  = rsp_color_ff;

   always_comb begin
      sts.clear_last = clr_cnt_ff == AW'(rlrp_pkg::MEM_DEPTH - 1);
      sts.line_last  = line_last;
      sts.rect_last  = rect_x_last && (cur_y_ff == ry_last_ff);
      sts.rect_empty = rect_empty_ff;
      sts.rsp_busy   = rsp_valid_ff && !rsp_tready;
   end

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (mem_we && !cmd.clear) |-> mem_addr < AW'(rlrp_pkg::MEM_DEPTH))
      else $error("pixel write outside the frame store");

   a_rect_on_screen: assert property (@(posedge clock) disable iff (reset)
      cmd.rect_step |-> on_screen)
      else $error("rectangle walk left the screen");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid_ff && !rsp_tready))
      else $error("response overwritten before it was taken");

endmodule

// ===== dv/tb_raster_line_rect_plotter.sv =====
`timescale 1ns / 100ps

module tb_raster_line_rect_plotter;

   // cycles with no accepted beat before the run is abandoned; covers the
   // clearing sweep after reset and a full-screen fill several times over
   localparam int QUIET_LIMIT = 100000;
   localparam int TAIL_CYCLES = 40;
   localparam int PHASES      = 14;
   localparam int PHASE_ITEMS = 100;

   typedef struct {
      rlrp_pkg::rlrp_kind_type             kind;
      logic signed [rlrp_pkg::COORD_W-1:0] xs;
      logic signed [rlrp_pkg::COORD_W-1:0] ys;
      logic signed [rlrp_pkg::COORD_W-1:0] xe;
      logic signed [rlrp_pkg::COORD_W-1:0] ye;
      logic signed [rlrp_pkg::COORD_W-1:0] w;
      logic signed [rlrp_pkg::COORD_W-1:0] h;
   } draw_cmd_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   // x_start, y_start, x_end, y_end, rect_width, rect_height
   logic [71:0] req_tdata   = '0;
   // req_type
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   // read_color, zero fill
   logic [7:0]  rsp_tdata;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // frame contents and registers as the block should hold them
   logic [rlrp_pkg::COLOR_W-1:0] frame_model [rlrp_pkg::MEM_DEPTH];
   logic                         model_enable;
   logic [rlrp_pkg::COLOR_W-1:0] model_color;
   logic [rlrp_pkg::COLOR_W-1:0] pending_colors [$];

   bit steady = 1'b0;
   int mismatch_count  = 0;
   int results_checked = 0;
   int csr_writes      = 0;
   int kind_count [4]  = '{0, 0, 0, 0};

   raster_line_rect_plotter dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   function automatic bit on_screen(int x, int y);
      return x >= 0 && x < rlrp_pkg::SCREEN_WIDTH && y >= 0 && y < rlrp_pkg::SCREEN_HEIGHT;
   endfunction

   // clip each pixel on its own
   function automatic void paint(int x, int y);
      if (on_screen(x, y)) frame_model[y * rlrp_pkg::SCREEN_WIDTH + x] = model_color;
   endfunction

   // walk the full Bresenham path, on screen or not
   function automatic void trace_line(int x0, int y0, int x1, int y1);
      int dx, dy, sx, sy, err, e2;
      bit done;
      dx   = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy   = -((y1 > y0) ? y1 - y0 : y0 - y1);
      sx   = (x0 < x1) ? 1 : -1;
      sy   = (y0 < y1) ? 1 : -1;
      err  = dx + dy;
      done = 1'b0;
      while (!done) begin
         paint(x0, y0);
         if (x0 == x1 && y0 == y1) begin
            done = 1'b1;
         end else begin
            e2 = 2 * err;
            if (e2 >= dy) begin
               err += dy;
               x0  += sx;
            end
            if (e2 <= dx) begin
               err += dx;
               y0  += sy;
            end
         end
      end
   endfunction

   // fill only the on-screen part; an empty size draws nothing
   function automatic void fill_box(int x, int y, int w, int h);
      int xa, xb, ya, yb;
      if (w <= 0 || h <= 0) return;
      xa = (x < 0) ? 0 : x;
      ya = (y < 0) ? 0 : y;
      xb = (x + w > rlrp_pkg::SCREEN_WIDTH) ? rlrp_pkg::SCREEN_WIDTH : x + w;
      yb = (y + h > rlrp_pkg::SCREEN_HEIGHT) ? rlrp_pkg::SCREEN_HEIGHT : y + h;
      for (int i = ya; i < yb; i++) begin
         for (int j = xa; j < xb; j++) paint(j, i);
      end
   endfunction

   // update the frame model and return the color the result beat carries
   function automatic logic [rlrp_pkg::COLOR_W-1:0] apply_command(draw_cmd_type c);
      int xs, ys;
      logic [rlrp_pkg::COLOR_W-1:0] color;
      xs    = int'(c.xs);
      ys    = int'(c.ys);
      color = '0;
      if (c.kind == rlrp_pkg::KIND_READ) begin
         if (on_screen(xs, ys)) color = frame_model[ys * rlrp_pkg::SCREEN_WIDTH + xs];
      end else if (model_enable) begin
         case (c.kind)
            rlrp_pkg::KIND_PLOT: paint(xs, ys);
            rlrp_pkg::KIND_LINE: trace_line(xs, ys, int'(c.xe), int'(c.ye));
            default:             fill_box(xs, ys, int'(c.w), int'(c.h));
         endcase
      end
      return color;
   endfunction

   // ---------------------------------------------------------------- helpers

   function automatic bit take_gap();
      return !steady && ($urandom_range(99) < 31);
   endfunction

   function automatic void report_mismatch(string what, logic [31:0] expected,
                                           logic [31:0] actual);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] %s mismatch: expected %0h, got %0h", $time, what, expected, actual);
   endfunction

   function automatic draw_cmd_type make_cmd(rlrp_pkg::rlrp_kind_type kind, int xs, int ys,
                                             int xe = 0, int ye = 0, int w = 0, int h = 0);
      draw_cmd_type c;
      c.kind = kind;
      c.xs   = rlrp_pkg::COORD_W'(xs);
      c.ys   = rlrp_pkg::COORD_W'(ys);
      c.xe   = rlrp_pkg::COORD_W'(xe);
      c.ye   = rlrp_pkg::COORD_W'(ye);
      c.w    = rlrp_pkg::COORD_W'(w);
      c.h    = rlrp_pkg::COORD_W'(h);
      return c;
   endfunction

   function automatic int near_screen(int span);
      return int'($urandom_range(span + 39)) - 20;
   endfunction

   // mostly coordinates around the screen and small boxes;
   // now and then full-range values and a full-screen fill
   function automatic draw_cmd_type random_cmd();
      draw_cmd_type c;
      int roll;
      roll = $urandom_range(99);
      if (roll < 25)      c.kind = rlrp_pkg::KIND_PLOT;
      else if (roll < 50) c.kind = rlrp_pkg::KIND_LINE;
      else if (roll < 65) c.kind = rlrp_pkg::KIND_RECT;
      else                c.kind = rlrp_pkg::KIND_READ;
      // unused fields carry noise
      c.xs = rlrp_pkg::COORD_W'($urandom);
      c.ys = rlrp_pkg::COORD_W'($urandom);
      c.xe = rlrp_pkg::COORD_W'($urandom);
      c.ye = rlrp_pkg::COORD_W'($urandom);
      c.w  = rlrp_pkg::COORD_W'($urandom);
      c.h  = rlrp_pkg::COORD_W'($urandom);
      if ($urandom_range(99) >= 5) begin
         c.xs = rlrp_pkg::COORD_W'(near_screen(rlrp_pkg::SCREEN_WIDTH));
         c.ys = rlrp_pkg::COORD_W'(near_screen(rlrp_pkg::SCREEN_HEIGHT));
      end
      if (c.kind == rlrp_pkg::KIND_LINE && $urandom_range(99) >= 3) begin
         c.xe = rlrp_pkg::COORD_W'(near_screen(rlrp_pkg::SCREEN_WIDTH));
         c.ye = rlrp_pkg::COORD_W'(near_screen(rlrp_pkg::SCREEN_HEIGHT));
      end
      if (c.kind == rlrp_pkg::KIND_RECT) begin
         roll = $urandom_range(99);
         if (roll == 0) begin
            c.xs = rlrp_pkg::COORD_W'(-int'($urandom_range(4)));
            c.ys = rlrp_pkg::COORD_W'(-int'($urandom_range(4)));
            c.w  = rlrp_pkg::COORD_W'(rlrp_pkg::SCREEN_WIDTH + 8);
            c.h  = rlrp_pkg::COORD_W'(rlrp_pkg::SCREEN_HEIGHT + 8);
         end else if (roll > 2) begin
            c.w = rlrp_pkg::COORD_W'(int'($urandom_range(24)) - 3);
            c.h = rlrp_pkg::COORD_W'(int'($urandom_range(24)) - 3);
         end
      end
      return c;
   endfunction

   // ---------------------------------------------------------------- drivers

   // present one command beat and record its expected result once accepted
   task automatic send_cmd(draw_cmd_type c);
      while (take_gap()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {c.h, c.w, c.ye, c.xe, c.ys, c.xs};
      req_tuser  <= c.kind;
      do @(posedge clock); while (!req_tready);
      pending_colors.push_back(apply_command(c));
      kind_count[c.kind]++;
   endtask

   // drop valid and hold until every result beat is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_colors.size() != 0);
   endtask

   // one register access; a read compares against data
   task automatic csr_access(bit is_write, logic [2:0] addr, logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= addr;
      csr_pwdata  <= is_write ? data : 32'h0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (is_write) begin
         csr_writes++;
         if (addr == rlrp_pkg::REG_DRAW_ENABLE)     model_enable = data[0];
         else if (addr == rlrp_pkg::REG_DRAW_COLOR) model_color  = data[rlrp_pkg::COLOR_W-1:0];
      end else if (csr_prdata !== data) begin
         report_mismatch($sformatf("register %0h readback", addr), data, csr_prdata);
      end
      @(posedge clock);
   endtask

   // write both registers with noise in the unused bits, then read them back
   task automatic set_config(bit enable, logic [rlrp_pkg::COLOR_W-1:0] color);
      logic [31:0] junk;
      junk = $urandom;
      drain_results();
      csr_access(1'b1, rlrp_pkg::REG_DRAW_ENABLE, {junk[31:1], enable});
      csr_access(1'b1, rlrp_pkg::REG_DRAW_COLOR, {junk[31:4], color});
      csr_access(1'b0, rlrp_pkg::REG_DRAW_ENABLE, {31'h0, enable});
      csr_access(1'b0, rlrp_pkg::REG_DRAW_COLOR, {28'h0, color});
   endtask

   // ---------------------------------------------------------------- checker

   // compare each result beat with the oldest expectation, drive ready with random gaps
   always @(posedge clock) begin : check_results
      logic [rlrp_pkg::COLOR_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_colors.size() == 0) begin
            report_mismatch("result beat with nothing pending", 'x, 32'(rsp_tdata));
         end else begin
            want = pending_colors.pop_front();
            results_checked++;
            if (rsp_tdata !== {4'h0, want})
               report_mismatch("read_color", 32'(want), 32'(rsp_tdata));
         end
      end
      rsp_tready <= !take_gap();
   end

   // abandon the run when no beat moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable && csr_pready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   // ---------------------------------------------------------------- tests

   task automatic test_reset_values();
      csr_access(1'b0, rlrp_pkg::REG_DRAW_ENABLE, 32'h1);
      csr_access(1'b0, rlrp_pkg::REG_DRAW_COLOR, 32'h0);
      send_cmd(make_cmd(rlrp_pkg::KIND_READ, 0, 0));
      send_cmd(make_cmd(rlrp_pkg::KIND_READ, rlrp_pkg::SCREEN_WIDTH - 1,
                        rlrp_pkg::SCREEN_HEIGHT - 1));
   endtask

   // corners, just off the left, right and bottom edges, and the coordinate extremes
   task automatic test_pixels();
      set_config(1'b1, 4'hF);
      send_cmd(make_cmd(rlrp_pkg::KIND_PLOT, 0, 0));
      send_cmd(make_cmd(rlrp_pkg::KIND_PLOT, rlrp_pkg::SCREEN_WIDTH - 1,
                        rlrp_pkg::SCREEN_HEIGHT - 1));
      send_cmd(make_cmd(rlrp_pkg::KIND_PLOT, -1, rlrp_pkg::SCREEN_HEIGHT - 1));
      send_cmd(make_cmd(rlrp_pkg::KIND_PLOT, rlrp_pkg::SCREEN_WIDTH, 0));
      send_cmd(make_cmd(rlrp_pkg::KIND_PLOT, 0, rlrp_pkg::SCREEN_HEIGHT));
      send_cmd(make_cmd(rlrp_pkg::KIND_PLOT, 2047, -2048));
      send_cmd(make_cmd(rlrp_pkg::KIND_READ, 0, 0));
      send_cmd(make_cmd(rlrp_pkg::KIND_READ, rlrp_pkg::SCREEN_WIDTH - 1,
                        rlrp_pkg::SCREEN_HEIGHT - 1));
      send_cmd(make_cmd(rlrp_pkg::KIND_READ, -1, rlrp_pkg::SCREEN_HEIGHT - 1));
      send_cmd(make_cmd(rlrp_pkg::KIND_READ, -2048, 2047));
   endtask

   // a one-point line, a steep line and a shallow one crossing off screen
   task automatic test_lines();
      set_config(1'b1, 4'h9);
      send_cmd(make_cmd(rlrp_pkg::KIND_LINE, 80, 50, 80, 50));
      send_cmd(make_cmd(rlrp_pkg::KIND_LINE, 5, -10, 9, rlrp_pkg::SCREEN_HEIGHT + 10));
      send_cmd(make_cmd(rlrp_pkg::KIND_LINE, -30, 60, rlrp_pkg::SCREEN_WIDTH + 40, 40));
      send_cmd(make_cmd(rlrp_pkg::KIND_READ, 80, 50));
   endtask

   // full-screen fill, empty sizes, an off-screen box and a clipped corner
   task automatic test_rects();
      set_config(1'b1, 4'h3);
      send_cmd(make_cmd(rlrp_pkg::KIND_RECT, -5, -5, 0, 0, 2047, 2047));
      set_config(1'b1, 4'h6);
      send_cmd(make_cmd(rlrp_pkg::KIND_RECT, 10, 10, 0, 0, 0, 5));
      send_cmd(make_cmd(rlrp_pkg::KIND_RECT, 10, 10, 0, 0, 5, -1));
      send_cmd(make_cmd(rlrp_pkg::KIND_RECT, -2048, -2048, 0, 0, 2047, 2047));
      send_cmd(make_cmd(rlrp_pkg::KIND_RECT, rlrp_pkg::SCREEN_WIDTH - 10,
                        rlrp_pkg::SCREEN_HEIGHT - 5, 0, 0, 20, 20));
      send_cmd(make_cmd(rlrp_pkg::KIND_READ, rlrp_pkg::SCREEN_WIDTH - 1,
                        rlrp_pkg::SCREEN_HEIGHT - 1));
      send_cmd(make_cmd(rlrp_pkg::KIND_READ, 0, 0));
   endtask

   task automatic test_draw_disabled();
      set_config(1'b0, 4'hC);
      send_cmd(make_cmd(rlrp_pkg::KIND_PLOT, 1, 1));
      send_cmd(make_cmd(rlrp_pkg::KIND_LINE, 0, 0, rlrp_pkg::SCREEN_WIDTH - 1,
                        rlrp_pkg::SCREEN_HEIGHT - 1));
      send_cmd(make_cmd(rlrp_pkg::KIND_RECT, 0, 0, 0, 0, rlrp_pkg::SCREEN_WIDTH,
                        rlrp_pkg::SCREEN_HEIGHT));
      send_cmd(make_cmd(rlrp_pkg::KIND_READ, 1, 1));
   endtask

   // phases of random commands under changing registers; one phase runs
   // without idling, another pauses halfway until the results are back
   task automatic test_random_mix();
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       set_config(1'b1, 4'h0);
            1:       set_config(1'b1, 4'hF);
            4, 10:   set_config(1'b0, rlrp_pkg::COLOR_W'($urandom));
            default: set_config(1'b1, rlrp_pkg::COLOR_W'($urandom));
         endcase
         steady = (phase == 6);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 8 && n == PHASE_ITEMS / 2) drain_results();
            send_cmd(random_cmd());
         end
      end
      steady = 1'b0;
   endtask

   // ---------------------------------------------------------------- main

   initial begin
      for (int i = 0; i < rlrp_pkg::MEM_DEPTH; i++) frame_model[i] = '0;
      model_enable = 1'b1;
      model_color  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_pixels();
      test_lines();
      test_rects();
      test_draw_disabled();
      test_random_mix();

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d plots, %0d lines, %0d boxes and %0d reads; %0d results compared",
               kind_count[rlrp_pkg::KIND_PLOT], kind_count[rlrp_pkg::KIND_LINE],
               kind_count[rlrp_pkg::KIND_RECT], kind_count[rlrp_pkg::KIND_READ],
               results_checked);
      $display("Register writes: %0d, drawing both on and off, colors from 0 to 15",
               csr_writes);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/rlrp_pkg.sv
rtl/rlrp_ctrl.sv
rtl/rlrp_datapath.sv
rtl/raster_line_rect_plotter.sv
dv/tb_raster_line_rect_plotter.sv
